// File: hw/rtl/rca_pkg.sv
// ----------------------------------------------------------------------------
// rca_pkg
// Shared constants and types for the rectangle clip ALU: opcodes, marker
// register defaults and the piece-select bundle handed from the evaluator.
// ----------------------------------------------------------------------------
package rca_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int MARKER_BITS    = 16;
	localparam int OPCODE_BITS    = 3;
	localparam int MAX_PIECES     = 4;

	localparam logic [MARKER_BITS-1:0] MARKER_RESET = 16'h8000;

	localparam logic [OPCODE_BITS-1:0] OP_INTERSECT = 3'd0;
	localparam logic [OPCODE_BITS-1:0] OP_BOUNDING  = 3'd1;
	localparam logic [OPCODE_BITS-1:0] OP_MERGE     = 3'd2;
	localparam logic [OPCODE_BITS-1:0] OP_SUBTRACT  = 3'd3;
	localparam logic [OPCODE_BITS-1:0] OP_VALID     = 3'd4;
	localparam logic [OPCODE_BITS-1:0] OP_CONTAINED = 3'd5;

	// Which result slots exist for an item, and the flag of each.
	typedef struct packed {
		logic [MAX_PIECES-1:0] mask;
		logic [MAX_PIECES-1:0] ok;
	} rca_sel_t;

endpackage

// File: hw/rtl/rect_clip_alu_core.sv
// ----------------------------------------------------------------------------
// rect_clip_alu_core
// Rectangle ALU on two inclusive rectangles: intersect, bounding box, merge,
// subtract (up to four pieces), validity and containment.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries opcode and rectangles A and B.
//   Output channel out_valid/out_ready carries one result rectangle, ok_flag
//   and last_piece per transfer. Every item yields one result, except
//   subtract, which yields one to four pieces (top, bottom, left, right).
//   Timing: an item is captured in the input register, and its first result
//   is loaded into the output register when that register is free or emptied.
//   Throughput: one item per cycle for single-result opcodes while out_ready is
//   high; a subtract holds the input register until its last piece is sent,
//   set by the single result register shared by all pieces.
//   Stall: while out_ready is low the result register holds and the input
//   register fills; in_ready then drops. A new input is taken in the same
//   cycle the last result of the held item moves to the output register.
//   Reset (arst_n low) empties both registers and sets the marker to -32768.
//   The marker register is written by cfg_we/cfg_wdata; the user must do so
//   only while the block idles, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module rect_clip_alu_core #(
	parameter int COORD_BITS = rca_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [rca_pkg::MARKER_BITS-1:0]    cfg_wdata,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rca_pkg::OPCODE_BITS-1:0]    opcode,
	input  logic signed [COORD_BITS-1:0]       a_left,
	input  logic signed [COORD_BITS-1:0]       a_top,
	input  logic signed [COORD_BITS-1:0]       a_right,
	input  logic signed [COORD_BITS-1:0]       a_bottom,
	input  logic signed [COORD_BITS-1:0]       b_left,
	input  logic signed [COORD_BITS-1:0]       b_top,
	input  logic signed [COORD_BITS-1:0]       b_right,
	input  logic signed [COORD_BITS-1:0]       b_bottom,
	// output channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [COORD_BITS-1:0]       out_left,
	output logic signed [COORD_BITS-1:0]       out_top,
	output logic signed [COORD_BITS-1:0]       out_right,
	output logic signed [COORD_BITS-1:0]       out_bottom,
	output logic                               ok_flag,
	output logic                               last_piece
);
	import rca_pkg::*;

	// marker register
	logic [MARKER_BITS-1:0]       marker_q;
	logic signed [COORD_BITS-1:0] marker_c;

	// input register (stage 1)
	logic                         item_valid_s1;
	logic [OPCODE_BITS-1:0]       opcode_s1;
	logic signed [COORD_BITS-1:0] a_left_s1, a_top_s1, a_right_s1, a_bottom_s1;
	logic signed [COORD_BITS-1:0] b_left_s1, b_top_s1, b_right_s1, b_bottom_s1;
	logic [MAX_PIECES-1:0]        done_q;     // pieces of the held item already sent

	// evaluator results
	logic signed [COORD_BITS-1:0] pc_left   [MAX_PIECES];
	logic signed [COORD_BITS-1:0] pc_top    [MAX_PIECES];
	logic signed [COORD_BITS-1:0] pc_right  [MAX_PIECES];
	logic signed [COORD_BITS-1:0] pc_bottom [MAX_PIECES];
	rca_sel_t                     sel;

	// piece selection
	logic [MAX_PIECES-1:0]        remaining;
	logic [MAX_PIECES-1:0]        pick;
	logic                         pick_last;
	logic                         advance;
	logic                         in_xfer;
	logic signed [COORD_BITS-1:0] nxt_left, nxt_top, nxt_right, nxt_bottom;
	logic                         nxt_ok;

	// output register (stage 2)
	logic                         out_valid_s2;
	logic signed [COORD_BITS-1:0] out_left_s2, out_top_s2, out_right_s2, out_bottom_s2;
	logic                         ok_flag_s2, last_piece_s2;

	// The marker is a signed 16-bit register value; it is sign extended from
	// bit 15 when the coordinates are wider and truncated when narrower.
	generate
		if (COORD_BITS > MARKER_BITS) begin : g_mk_wide
			assign marker_c = {{(COORD_BITS-MARKER_BITS){marker_q[MARKER_BITS-1]}}, marker_q};
		end else if (COORD_BITS == MARKER_BITS) begin : g_mk_same
			assign marker_c = marker_q;
		end else begin : g_mk_narrow
			assign marker_c = marker_q[COORD_BITS-1:0];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (cfg_we) begin
			marker_q <= cfg_wdata;
		end
	end

	rca_eval #(
		.COORD_BITS (COORD_BITS)
	) u_eval (
		.opcode    (opcode_s1),
		.a_left    (a_left_s1),
		.a_top     (a_top_s1),
		.a_right   (a_right_s1),
		.a_bottom  (a_bottom_s1),
		.b_left    (b_left_s1),
		.b_top     (b_top_s1),
		.b_right   (b_right_s1),
		.b_bottom  (b_bottom_s1),
		.marker    (marker_c),
		.pc_left   (pc_left),
		.pc_top    (pc_top),
		.pc_right  (pc_right),
		.pc_bottom (pc_bottom),
		.sel       (sel)
	);

	// Next piece to send is the lowest one not yet sent; the item is done
	// when that piece is the only one left.
	always_comb begin
		remaining  = sel.mask & ~done_q;
		pick       = remaining & (~remaining + MAX_PIECES'(1));
		pick_last  = (remaining & ~pick) == '0;
		nxt_left   = '0;
		nxt_top    = '0;
		nxt_right  = '0;
		nxt_bottom = '0;
		nxt_ok     = 1'b0;
		for (int i = 0; i < MAX_PIECES; i++) begin
			if (pick[i]) begin
				nxt_left   = nxt_left   | pc_left[i];
				nxt_top    = nxt_top    | pc_top[i];
				nxt_right  = nxt_right  | pc_right[i];
				nxt_bottom = nxt_bottom | pc_bottom[i];
				nxt_ok     = nxt_ok     | sel.ok[i];
			end
		end
	end

	// result register free or being emptied this cycle
	assign advance  = !out_valid_s2 || out_ready;
	assign in_ready = !item_valid_s1 || (advance && pick_last);
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			done_q        <= '0;
		end else if (in_xfer) begin
			item_valid_s1 <= 1'b1;
			done_q        <= '0;
		end else if (item_valid_s1 && advance) begin
			if (pick_last) begin
				item_valid_s1 <= 1'b0;
			end
			done_q <= done_q | pick;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			opcode_s1   <= opcode;
			a_left_s1   <= a_left;
			a_top_s1    <= a_top;
			a_right_s1  <= a_right;
			a_bottom_s1 <= a_bottom;
			b_left_s1   <= b_left;
			b_top_s1    <= b_top;
			b_right_s1  <= b_right;
			b_bottom_s1 <= b_bottom;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid_s1) begin
			out_left_s2   <= nxt_left;
			out_top_s2    <= nxt_top;
			out_right_s2  <= nxt_right;
			out_bottom_s2 <= nxt_bottom;
			ok_flag_s2    <= nxt_ok;
			last_piece_s2 <= pick_last;
		end
	end

	assign out_valid  = out_valid_s2;
	assign out_left   = out_left_s2;
	assign out_top    = out_top_s2;
	assign out_right  = out_right_s2;
	assign out_bottom = out_bottom_s2;
	assign ok_flag    = ok_flag_s2;
	assign last_piece = last_piece_s2;

endmodule

// File: hw/rtl/rca_eval.sv
// ----------------------------------------------------------------------------
// rca_eval
// Combinational evaluator: forms every result rectangle of one item (up to
// four subtract pieces, one slot for all other opcodes) and their flags.
// ----------------------------------------------------------------------------
module rca_eval #(
	parameter int COORD_BITS = rca_pkg::COORD_BITS_DEF
) (
	input  logic [rca_pkg::OPCODE_BITS-1:0] opcode,
	input  logic signed [COORD_BITS-1:0]    a_left,
	input  logic signed [COORD_BITS-1:0]    a_top,
	input  logic signed [COORD_BITS-1:0]    a_right,
	input  logic signed [COORD_BITS-1:0]    a_bottom,
	input  logic signed [COORD_BITS-1:0]    b_left,
	input  logic signed [COORD_BITS-1:0]    b_top,
	input  logic signed [COORD_BITS-1:0]    b_right,
	input  logic signed [COORD_BITS-1:0]    b_bottom,
	input  logic signed [COORD_BITS-1:0]    marker,
	output logic signed [COORD_BITS-1:0]    pc_left   [rca_pkg::MAX_PIECES],
	output logic signed [COORD_BITS-1:0]    pc_top    [rca_pkg::MAX_PIECES],
	output logic signed [COORD_BITS-1:0]    pc_right  [rca_pkg::MAX_PIECES],
	output logic signed [COORD_BITS-1:0]    pc_bottom [rca_pkg::MAX_PIECES],
	output rca_pkg::rca_sel_t               sel
);
	import rca_pkg::*;

	function automatic logic rect_ok(
		input logic signed [COORD_BITS-1:0] l,
		input logic signed [COORD_BITS-1:0] t,
		input logic signed [COORD_BITS-1:0] r,
		input logic signed [COORD_BITS-1:0] b,
		input logic signed [COORD_BITS-1:0] m
	);
		rect_ok = (l != m) && (t != m) && (r != m) && (b != m) && (l <= r) && (t <= b);
	endfunction

	logic signed [COORD_BITS-1:0] isx_l, isx_t, isx_r, isx_b;
	logic signed [COORD_BITS-1:0] bnd_l, bnd_t, bnd_r, bnd_b;
	logic signed [COORD_BITS-1:0] trim_t, trim_b;
	logic                         cut_top, cut_bot, cut_left, cut_right;
	logic                         mrg_x, mrg_y;

	always_comb begin
		isx_l = (a_left   > b_left)   ? a_left   : b_left;
		isx_t = (a_top    > b_top)    ? a_top    : b_top;
		isx_r = (a_right  < b_right)  ? a_right  : b_right;
		isx_b = (a_bottom < b_bottom) ? a_bottom : b_bottom;
		bnd_l = (a_left   < b_left)   ? a_left   : b_left;
		bnd_t = (a_top    < b_top)    ? a_top    : b_top;
		bnd_r = (a_right  > b_right)  ? a_right  : b_right;
		bnd_b = (a_bottom > b_bottom) ? a_bottom : b_bottom;

		// Merge: equal left and right sides take priority over equal top and bottom sides.
		mrg_x = (a_left == b_left) && (a_right == b_right);
		mrg_y = (a_top == b_top) && (a_bottom == b_bottom);

		// Subtract: top/bottom cuts trim A before the side pieces.
		cut_top   = a_top < b_top;
		cut_bot   = a_bottom > b_bottom;
		trim_t    = cut_top ? b_top : a_top;
		trim_b    = cut_bot ? b_bottom : a_bottom;
		cut_left  = a_left < b_left;
		cut_right = a_right > b_right;

		for (int i = 0; i < MAX_PIECES; i++) begin
			pc_left[i]   = marker;
			pc_top[i]    = marker;
			pc_right[i]  = marker;
			pc_bottom[i] = marker;
		end
		sel.mask = 4'b0001;
		sel.ok   = '0;

		case (opcode)
			OP_INTERSECT: begin
				pc_left[0] = isx_l; pc_top[0] = isx_t;
				pc_right[0] = isx_r; pc_bottom[0] = isx_b;
				sel.ok[0] = rect_ok(isx_l, isx_t, isx_r, isx_b, marker);
			end
			OP_BOUNDING: begin
				pc_left[0] = bnd_l; pc_top[0] = bnd_t;
				pc_right[0] = bnd_r; pc_bottom[0] = bnd_b;
				sel.ok[0] = rect_ok(bnd_l, bnd_t, bnd_r, bnd_b, marker);
			end
			OP_MERGE: begin
				if (mrg_x) begin
					if (!(a_bottom < b_top || b_bottom < a_top)) begin
						pc_left[0] = a_left; pc_right[0] = a_right;
						pc_top[0] = bnd_t; pc_bottom[0] = bnd_b;
						sel.ok[0] = 1'b1;
					end
				end else if (mrg_y) begin
					if (!(a_right < b_left || b_right < a_left)) begin
						pc_top[0] = a_top; pc_bottom[0] = a_bottom;
						pc_left[0] = bnd_l; pc_right[0] = bnd_r;
						sel.ok[0] = 1'b1;
					end
				end
			end
			OP_SUBTRACT: begin
				pc_left[0] = a_left; pc_top[0] = a_top;
				pc_right[0] = a_right; pc_bottom[0] = b_top;
				pc_left[1] = a_left; pc_top[1] = b_bottom;
				pc_right[1] = a_right; pc_bottom[1] = a_bottom;
				pc_left[2] = a_left; pc_top[2] = trim_t;
				pc_right[2] = b_left; pc_bottom[2] = trim_b;
				pc_left[3] = b_right; pc_top[3] = trim_t;
				pc_right[3] = a_right; pc_bottom[3] = trim_b;
				sel.mask = {cut_right, cut_left, cut_bot, cut_top};
				sel.ok   = sel.mask;
				if (sel.mask == '0) begin
					// nothing left: one marker result with the flag clear
					for (int i = 0; i < MAX_PIECES; i++) begin
						pc_left[i]   = marker;
						pc_top[i]    = marker;
						pc_right[i]  = marker;
						pc_bottom[i] = marker;
					end
					sel.mask = 4'b0001;
				end
			end
			OP_VALID: begin
				pc_left[0] = a_left; pc_top[0] = a_top;
				pc_right[0] = a_right; pc_bottom[0] = a_bottom;
				sel.ok[0] = rect_ok(a_left, a_top, a_right, a_bottom, marker);
			end
			OP_CONTAINED: begin
				pc_left[0] = a_left; pc_top[0] = a_top;
				pc_right[0] = a_right; pc_bottom[0] = a_bottom;
				sel.ok[0] = (a_left >= b_left) && (a_right <= b_right) &&
					(a_top >= b_top) && (a_bottom <= b_bottom);
			end
			default: begin
				sel.mask = 4'b0001;
			end
		endcase
	end

endmodule
